/* rtl/tdls_pkg.sv */
`default_nettype none

package tdls_pkg;

  // Pattern store geometry (address field is a fixed byte)
  localparam int STORE_DEPTH  = 256;
  localparam int STORE_ADDR_W = 8;
  localparam int BYTE_W       = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PERIOD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_PERIOD   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd2;

  localparam logic [15:0] LONG_PERIOD_RST    = 16'd100;
  localparam logic [7:0]  SHORT_PERIOD_RST   = 8'd3;
  localparam logic [7:0]  DEBOUNCE_LIMIT_RST = 8'd7;

  // Scan byte counter, holds up to NUM_BLOCKS + 1
  localparam int SENT_W = 4;

  // Transaction modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READY = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic              button_level;
    logic              time_set_busy;
    logic [BYTE_W-1:0] write_address;
    logic [BYTE_W-1:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic              time_advance;
    logic              time_adjust;
    logic              button_pressed;
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              latch_strobe;
    logic              leds_on;
  } out_item_t;

  // Access request from the control unit to the pattern store
  typedef struct packed {
    logic                    rd_en;
    logic                    wr_en;
    logic [STORE_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]       wr_data;
  } store_req_t;

endpackage

`default_nettype wire

/* rtl/tdls_if.sv */
`default_nettype none

// Input item channel
interface tdls_in_if;
  logic               valid;
  logic               ready;
  tdls_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result item channel
interface tdls_out_if;
  logic                valid;
  logic                ready;
  tdls_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel
interface tdls_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [tdls_pkg::CFG_INDEX_W-1:0]     index;
  logic [tdls_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/tdls_ram.sv */
`default_nettype none

module tdls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/tdls_store.sv */
`default_nettype none

module tdls_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tdls_pkg::store_req_t        req,
  output logic [tdls_pkg::BYTE_W-1:0]      rd_data
);

  import tdls_pkg::*;

  logic [STORE_DEPTH-1:0] valid_r;
  logic                   hit_r;
  logic [BYTE_W-1:0]      ram_rdata;

  tdls_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .re    (req.rd_en),
    .addr  (req.addr),
    .wdata (req.wr_data),
    .rdata (ram_rdata)
  );

  // Mark written entries; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  // Sample the entry's valid bit alongside the RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (req.rd_en) begin
      hit_r <= valid_r[req.addr];
    end
  end

  assign rd_data = hit_r ? ram_rdata : '0;

endmodule

`default_nettype wire

/* rtl/tdls_ctrl.sv */
`default_nettype none

module tdls_ctrl #(
  parameter int NUM_COLUMNS = 32,
  parameter int NUM_BLOCKS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              acc,
  input  wire tdls_pkg::in_item_t                item,
  input  wire logic                              cfg_wr,
  input  wire logic [tdls_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tdls_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tdls_pkg::store_req_t                   req,
  output tdls_pkg::out_item_t                    res,
  output logic                                   use_store
);

  import tdls_pkg::*;

  localparam int COL_W = $clog2(NUM_COLUMNS);

  // Configuration registers
  logic [15:0] long_period_r;
  logic [7:0]  short_period_r;
  logic [7:0]  limit_r;

  // Timing, debounce and scan state
  logic [15:0]      long_count_r,    long_count_nxt;
  logic [7:0]       short_count_r,   short_count_nxt;
  logic [7:0]       high_run_r,      high_run_nxt;
  logic [7:0]       low_run_r,       low_run_nxt;
  logic             debounced_r,     debounced_nxt;
  logic             refresh_ready_r, refresh_ready_nxt;
  logic             scan_active_r,   scan_active_nxt;
  logic [SENT_W-1:0] sent_count_r,   sent_count_nxt;
  logic [COL_W-1:0] column_r,        column_nxt;
  logic             led_enable_r,    led_enable_nxt;

  logic [15:0]      long_dec;
  logic [7:0]       short_dec;
  logic [8:0]       bump;
  logic [15:0]      addr_full;
  logic [COL_W:0]   column_inc;

  // Saturating run counter step: {flip, new run}
  function automatic logic [8:0] run_bump(input logic [7:0] run, input logic [7:0] limit);
    logic [8:0] clamp;
    logic [8:0] r;
    logic       flip;
    clamp = {1'b0, limit} + 9'd1;
    if (clamp > 9'd255) clamp = 9'd255;
    r = {1'b0, run} + 9'd1;
    if (r > 9'd255) r = 9'd255;
    flip = 1'b0;
    if (r > {1'b0, limit}) begin
      r    = clamp;
      flip = (clamp > {1'b0, limit});
    end
    return {flip, r[7:0]};
  endfunction

  assign long_dec   = long_count_r - 16'd1;
  assign short_dec  = short_count_r - 8'd1;
  assign addr_full  = 16'(sent_count_r) * 16'(NUM_COLUMNS) + 16'(column_r);
  assign column_inc = {1'b0, column_r} + (COL_W+1)'(1);
  assign bump       = run_bump(item.button_level ? high_run_r : low_run_r, limit_r);

  // Next state and result for the accepted transaction
  always_comb begin
    long_count_nxt    = long_count_r;
    short_count_nxt   = short_count_r;
    high_run_nxt      = high_run_r;
    low_run_nxt       = low_run_r;
    debounced_nxt     = debounced_r;
    refresh_ready_nxt = refresh_ready_r;
    scan_active_nxt   = scan_active_r;
    sent_count_nxt    = sent_count_r;
    column_nxt        = column_r;
    led_enable_nxt    = led_enable_r;
    res               = '0;
    req               = '0;
    use_store         = 1'b0;

    if (acc) begin
      unique case (item.mode)
        MODE_TICK: begin
          // Long divider
          long_count_nxt = long_dec;
          if (long_dec == '0) begin
            long_count_nxt   = long_period_r;
            res.time_advance = !item.time_set_busy;
          end
          // Short divider and button sample
          if (short_count_r != '0) begin
            short_count_nxt = short_dec;
            if (short_dec == '0) begin
              short_count_nxt = short_period_r;
              res.time_adjust = 1'b1;
              if (item.button_level) begin
                low_run_nxt  = '0;
                high_run_nxt = bump[7:0];
                if (bump[8]) debounced_nxt = 1'b0;
              end else begin
                high_run_nxt = '0;
                low_run_nxt  = bump[7:0];
                if (bump[8]) debounced_nxt = 1'b1;
              end
            end
          end
          // Start a scan once the last refresh is done
          if (refresh_ready_r) begin
            refresh_ready_nxt = 1'b0;
            sent_count_nxt    = '0;
            scan_active_nxt   = 1'b1;
            led_enable_nxt    = 1'b0;
          end
        end
        MODE_READY: begin
          if (scan_active_r) begin
            if (sent_count_r < SENT_W'(NUM_BLOCKS)) begin
              // Pattern byte comes from the store's registered read in the next cycle
              req.rd_en      = 1'b1;
              req.addr       = addr_full[STORE_ADDR_W-1:0];
              use_store      = 1'b1;
              res.send_valid = 1'b1;
              sent_count_nxt = sent_count_r + SENT_W'(1);
            end else if (sent_count_r == SENT_W'(NUM_BLOCKS)) begin
              res.send_valid = 1'b1;
              res.send_byte  = BYTE_W'(column_r);
              sent_count_nxt = sent_count_r + SENT_W'(1);
              if (column_inc >= (COL_W+1)'(NUM_COLUMNS)) begin
                column_nxt = '0;
              end else begin
                column_nxt = column_inc[COL_W-1:0];
              end
            end else begin
              res.latch_strobe  = 1'b1;
              led_enable_nxt    = 1'b1;
              refresh_ready_nxt = 1'b1;
              scan_active_nxt   = 1'b0;
            end
          end
        end
        MODE_WRITE: begin
          req.wr_en   = 1'b1;
          req.addr    = item.write_address;
          req.wr_data = item.write_byte;
        end
        default: begin
        end
      endcase
    end

    res.button_pressed = debounced_nxt;
    res.leds_on        = led_enable_nxt;
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_period_r  <= LONG_PERIOD_RST;
      short_period_r <= SHORT_PERIOD_RST;
      limit_r        <= DEBOUNCE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_LONG_PERIOD:    long_period_r  <= cfg_data;
        CFG_SHORT_PERIOD:   short_period_r <= cfg_data[7:0];
        CFG_DEBOUNCE_LIMIT: limit_r        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_count_r    <= LONG_PERIOD_RST;
      short_count_r   <= SHORT_PERIOD_RST;
      high_run_r      <= '0;
      low_run_r       <= '0;
      debounced_r     <= 1'b0;
      refresh_ready_r <= 1'b1;
      scan_active_r   <= 1'b0;
      sent_count_r    <= '0;
      column_r        <= '0;
      led_enable_r    <= 1'b1;
    end else begin
      long_count_r    <= long_count_nxt;
      short_count_r   <= short_count_nxt;
      high_run_r      <= high_run_nxt;
      low_run_r       <= low_run_nxt;
      debounced_r     <= debounced_nxt;
      refresh_ready_r <= refresh_ready_nxt;
      scan_active_r   <= scan_active_nxt;
      sent_count_r    <= sent_count_nxt;
      column_r        <= column_nxt;
      led_enable_r    <= led_enable_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tick_debounce_led_scan.sv */
// An accepted input's result moves through the read stage, then the output register.
// Throughput: one transaction per cycle while out_ch is not stalled; a pattern byte
// is one read of the single-port pattern store, issued at accept and merged into the
// result as it leaves the read stage.
// Reset (synchronous, rst_n low): registers take their default periods, the scan
// is idle with LEDs on, and every pattern store entry reads as zero at once.
`default_nettype none

module tick_debounce_led_scan #(
  parameter int NUM_COLUMNS = 32,
  parameter int NUM_BLOCKS  = 8
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tdls_in_if.sink   in_ch,
  tdls_out_if.source out_ch,
  tdls_cfg_if.sink  cfg_ch
);

  import tdls_pkg::*;

  logic              in_acc;
  store_req_t        req;
  out_item_t         res;
  logic              use_store;
  logic [BYTE_W-1:0] store_data;

  logic      s1_valid_r;
  out_item_t s1_item_r;
  logic      s1_store_r;
  logic      s1_move;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  assign s1_move      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_move;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  tdls_ctrl #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .item      (in_ch.data),
    .cfg_wr    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .req       (req),
    .res       (res),
    .use_store (use_store)
  );

  tdls_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (store_data)
  );

  // Read stage: hold the result while the store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r  <= res;
      s1_store_r <= use_store;
    end
  end

  // Merge the pattern byte into the result
  always_comb begin
    out_item_nxt = s1_item_r;
    if (s1_store_r) begin
      out_item_nxt.send_byte = store_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule

`default_nettype wire

/* dv/tick_debounce_led_scan_test.sv */
module tick_debounce_led_scan_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tdls_pkg::*;

  localparam int NUM_COLUMNS   = 32;
  localparam int NUM_BLOCKS    = 8;
  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 150;
  localparam int QUIET_LIMIT   = 2000;

  // Tracks the scanner state and queues the outputs each transaction should produce
  class led_scan_board;
    logic [15:0] long_per, long_cnt;
    logic [7:0]  short_per, short_cnt, limit, high_run, low_run;
    logic [7:0]  store [0:255];
    bit          pressed, refresh_done, scanning, leds;
    int          sent, col;
    out_item_t   awaited [$];
    int          errors;
    int          n_inputs, n_ticks, n_bytes, n_scans, n_advance, n_samples, n_flips, n_wraps;

    function new();
      long_per  = LONG_PERIOD_RST;
      short_per = SHORT_PERIOD_RST;
      limit     = DEBOUNCE_LIMIT_RST;
      long_cnt  = long_per;
      short_cnt = short_per;
      high_run  = '0;
      low_run   = '0;
      pressed   = 1'b0;
      refresh_done = 1'b1;
      scanning  = 1'b0;
      leds      = 1'b1;
      sent      = 0;
      col       = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LONG_PERIOD:    long_per  = data;
        CFG_SHORT_PERIOD:   short_per = data[7:0];
        CFG_DEBOUNCE_LIMIT: limit     = data[7:0];
        default: ;
      endcase
    endfunction

    // Saturating run counter; flip when the run passes the limit
    function logic [7:0] bump_run(logic [7:0] run, output bit flip);
      int clamp;
      int r;
      clamp = int'(limit) + 1;
      if (clamp > 255) clamp = 255;
      r = int'(run) + 1;
      if (r > 255) r = 255;
      flip = 1'b0;
      if (r > int'(limit)) begin
        r = clamp;
        flip = (r > int'(limit));
      end
      return r[7:0];
    endfunction

    function out_item_t advance_scanner(in_item_t item);
      out_item_t res;
      bit        flip;
      bit        was_pressed;
      res = '0;
      was_pressed = pressed;
      case (item.mode)
        MODE_TICK: begin
          n_ticks++;
          long_cnt = long_cnt - 16'd1;
          if (long_cnt == 16'd0) begin
            long_cnt = long_per;
            res.time_advance = !item.time_set_busy;
          end
          // Sample the button when the short divider expires
          if (short_cnt != 8'd0) begin
            short_cnt = short_cnt - 8'd1;
            if (short_cnt == 8'd0) begin
              short_cnt = short_per;
              if (item.button_level) begin
                low_run  = '0;
                high_run = bump_run(high_run, flip);
                if (flip) pressed = 1'b0;
              end else begin
                high_run = '0;
                low_run  = bump_run(low_run, flip);
                if (flip) pressed = 1'b1;
              end
              res.time_adjust = 1'b1;
            end
          end
          // Start a new scan once the last refresh is done
          if (refresh_done) begin
            refresh_done = 1'b0;
            sent         = 0;
            scanning     = 1'b1;
            leds         = 1'b0;
          end
        end
        MODE_READY: begin
          if (scanning) begin
            if (sent < NUM_BLOCKS) begin
              res.send_valid = 1'b1;
              res.send_byte  = store[(sent * NUM_COLUMNS + col) & 8'hFF];
              sent++;
            end else if (sent == NUM_BLOCKS) begin
              res.send_valid = 1'b1;
              res.send_byte  = col[7:0];
              sent++;
              col++;
              if (col >= NUM_COLUMNS) begin
                col = 0;
                n_wraps++;
              end
            end else begin
              res.latch_strobe = 1'b1;
              leds         = 1'b1;
              refresh_done = 1'b1;
              scanning     = 1'b0;
              n_scans++;
            end
          end
        end
        MODE_WRITE: store[item.write_address] = item.write_byte;
        default: ;
      endcase
      res.button_pressed = pressed;
      res.leds_on        = leds;
      if (res.time_advance) n_advance++;
      if (res.time_adjust) n_samples++;
      if (res.send_valid) n_bytes++;
      if (pressed != was_pressed) n_flips++;
      return res;
    endfunction

    function void take_input(in_item_t item);
      n_inputs++;
      awaited.push_back(advance_scanner(item));
    endfunction

    function int compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("output transaction with nothing expected: %p", got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      errors += compare_field("time_advance", want.time_advance, got.time_advance);
      errors += compare_field("time_adjust", want.time_adjust, got.time_adjust);
      errors += compare_field("button_pressed", want.button_pressed, got.button_pressed);
      errors += compare_field("send_valid", want.send_valid, got.send_valid);
      errors += compare_field("send_byte", want.send_byte, got.send_byte);
      errors += compare_field("latch_strobe", want.latch_strobe, got.latch_strobe);
      errors += compare_field("leds_on", want.leds_on, got.leds_on);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tdls_in_if  in_ch ();
  tdls_out_if out_ch ();
  tdls_cfg_if cfg_ch ();

  tick_debounce_led_scan #(
    .NUM_COLUMNS(NUM_COLUMNS),
    .NUM_BLOCKS (NUM_BLOCKS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  led_scan_board board = new();

  int   burst_left;
  int   results_seen;
  int   quiet_cycles;
  bit   hold_done;
  logic button_now;

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;
  wire cfg_fire = cfg_ch.valid && cfg_ch.ready;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Observe every transaction on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_fire) board.set_register(cfg_ch.index, cfg_ch.data);
      if (in_fire) board.take_input(in_ch.data);
      if (out_fire) begin
        board.check_output(out_ch.data);
        results_seen <= results_seen + 1;
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire || cfg_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result receiver: changing stall patterns plus one long hold-off
  initial begin : result_sink
    int stall_kind;
    int span;
    stall_kind = 0;
    span = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= 350) begin
        out_ch.ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          stall_kind = $urandom_range(0, 3);
          span = $urandom_range(16, 64);
        end
        span--;
        case (stall_kind)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] mode, logic level, logic busy,
                                         logic [7:0] addr, logic [7:0] wbyte);
    in_item_t item;
    item.mode          = mode;
    item.button_level  = level;
    item.time_set_busy = busy;
    item.write_address = addr;
    item.write_byte    = wbyte;
    return item;
  endfunction

  // Offer one transaction in bursts with random gaps; return once accepted
  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Tick with a slowly changing button level and occasional bounce
  task automatic send_tick();
    logic lvl;
    if ($urandom_range(0, 31) == 0) button_now = ~button_now;
    lvl = ($urandom_range(0, 11) == 0) ? ~button_now : button_now;
    send_item(make_item(MODE_TICK, lvl, ($urandom_range(0, 3) == 0),
                        8'($urandom), 8'($urandom)));
  endtask

  task automatic send_ready();
    send_item(make_item(MODE_READY, 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic send_write();
    send_item(make_item(MODE_WRITE, 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait for every expected output to arrive
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    // Let the monitor record the last accepted input first
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timing(input logic [15:0] lp, input logic [7:0] sp, input logic [7:0] lim);
    settle();
    write_reg(CFG_LONG_PERIOD, lp);
    write_reg(CFG_SHORT_PERIOD, 16'(sp));
    write_reg(CFG_DEBOUNCE_LIMIT, 16'(lim));
  endtask

  // Mostly complete scans and tick runs, some loose noise
  task automatic run_traffic(input int n);
    int done_n;
    int kind;
    int k;
    done_n = 0;
    while (done_n < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        send_tick();
        done_n++;
        for (k = 0; k < NUM_BLOCKS + 2; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 0) send_write();
            else send_tick();
            done_n++;
          end
          send_ready();
          done_n++;
        end
      end else if (kind <= 7) begin
        repeat ($urandom_range(1, 24)) begin
          send_tick();
          done_n++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          k = $urandom_range(0, 2);
          if (k == 0) begin
            send_tick();
            done_n++;
          end else if (k == 1) begin
            send_write();
            done_n++;
          end else begin
            send_ready();
          end
        end
      end
    end
  endtask

  initial begin : stimulus
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    burst_left   = 0;
    results_seen = 0;
    hold_done    = 1'b0;
    button_now   = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Pattern store extremes, including the bytes scanned for column 0
    send_item(make_item(MODE_WRITE, 1'b0, 1'b0, 8'd0, 8'hFF));
    send_item(make_item(MODE_WRITE, 1'b1, 1'b1, 8'd255, 8'hA5));
    send_item(make_item(MODE_WRITE, 1'b0, 1'b1, 8'd224, 8'h5A));
    send_item(make_item(MODE_WRITE, 1'b1, 1'b0, 8'd31, 8'h00));
    // Ready while no scan is active is ignored
    send_ready();
    // Tick starts a scan, then the full byte sequence and the latch
    send_item(make_item(MODE_TICK, 1'b1, 1'b0, 8'hFF, 8'h00));
    repeat (NUM_BLOCKS + 2) send_ready();
    send_ready();
    // Ticks with both button levels, busy and not busy
    send_item(make_item(MODE_TICK, 1'b0, 1'b1, 8'h00, 8'hFF));
    send_item(make_item(MODE_TICK, 1'b1, 1'b1, 8'h55, 8'hAA));
    send_item(make_item(MODE_TICK, 1'b0, 1'b0, 8'hAA, 8'h55));

    run_traffic(200);
    set_timing(16'd1, 8'd1, 8'd1);
    run_traffic(200);
    set_timing(16'hFFFF, 8'hFF, 8'd254);
    run_traffic(120);
    set_timing(16'($urandom_range(2, 40)), 8'($urandom_range(1, 4)), 8'($urandom_range(1, 12)));
    run_traffic(250);
    set_timing(16'($urandom_range(1, 8)), 8'($urandom_range(1, 3)), 8'($urandom_range(1, 6)));
    run_traffic(230);
    settle();

    if (board.pending() != 0) begin
      $error("%0d expected outputs never arrived", board.pending());
      board.errors++;
    end
    $display("Run covered %0d inputs (%0d ticks), %0d scans, %0d bytes sent, %0d column wraps.",
             board.n_inputs, board.n_ticks, board.n_scans, board.n_bytes, board.n_wraps);
    $display("Saw %0d time pulses, %0d button samples, %0d debounce flips; long stall %s.",
             board.n_advance, board.n_samples, board.n_flips, hold_done ? "applied" : "missed");
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
